>>> hdl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam int DEFAULT_MAX_WINDOW   = 32;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;
    localparam int CFG_WIDTH            = 6;

    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 6'd3;

    // per-cycle command broadcast along the sorting chain
    typedef struct packed {
        logic clear;    // empty every cell before a new sort
        logic shift;    // move every held value one cell towards cell 0
    } swm_cell_ctrl_t;

endpackage

>>> hdl/swm_ifs.sv
`timescale 1ns / 1ps

interface swm_sample_if
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_WIDTH:0] median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface

interface swm_cfg_if
    import swm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_WIDTH-1:0] win_len;

    modport source (output valid, output win_len, input ready);
    modport sink   (input valid, input win_len, output ready);
endinterface

>>> hdl/swm_cell.sv
`timescale 1ns / 1ps

// One insertion cell: keeps the smaller value, passes the larger one right.
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_cell_ctrl_t                 ctrl,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] in_data,
    input  logic signed [SAMPLE_WIDTH-1:0] right_data,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] out_data,
    output logic signed [SAMPLE_WIDTH-1:0] held_data
);

    logic                           full_reg;
    logic                           link_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] held_reg;
    logic signed [SAMPLE_WIDTH-1:0] link_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= 1'b0;
            link_vld_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            full_reg     <= 1'b0;
            link_vld_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            link_vld_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            full_reg     <= 1'b1;
            link_vld_reg <= full_reg;
        end
        else
        begin
            link_vld_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            held_reg <= right_data;
        end
        else if (in_valid)
        begin
            if (!full_reg)
            begin
                held_reg <= in_data;
            end
            else if (in_data < held_reg)
            begin
                held_reg <= in_data;
                link_reg <= held_reg;
            end
            else
            begin
                link_reg <= in_data;
            end
        end
    end

    assign out_valid = link_vld_reg;
    assign out_data  = link_reg;
    assign held_data = held_reg;

endmodule

>>> hdl/swm_chain.sv
`timescale 1ns / 1ps

// Row of insertion cells; after settling, cell 0 holds the smallest value.
module swm_chain
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = DEFAULT_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_cell_ctrl_t                 ctrl,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] in_data,
    output logic signed [SAMPLE_WIDTH-1:0] head_data
);

    logic                           link_vld [MAX_WINDOW+1];
    logic signed [SAMPLE_WIDTH-1:0] link_data [MAX_WINDOW+1];
    logic signed [SAMPLE_WIDTH-1:0] held [MAX_WINDOW+1];

    assign link_vld[0]       = in_valid;
    assign link_data[0]      = in_data;
    assign held[MAX_WINDOW]  = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .in_valid   (link_vld[i]),
            .in_data    (link_data[i]),
            .right_data (held[i+1]),
            .out_valid  (link_vld[i+1]),
            .out_data   (link_data[i+1]),
            .held_data  (held[i])
        );
    end

    assign head_data = held[0];

endmodule

>>> hdl/sliding_window_median.sv
`timescale 1ns / 1ps

// Running median filter. Each accepted sample is stored in a ring of
// MAX_WINDOW entries; once at least K samples have arrived since reset
// (K = the window length register, 0 read as 1, clipped to MAX_WINDOW) every
// sample yields one result: twice the median of the last K samples, so an
// even window's mean of the two middle values stays exact. Before the window
// has filled, a sample yields no result. Items are handled one at a time. An
// emitting sample's K window samples are read from the ring one per cycle
// into a chain of insertion cells, the chain is left to settle, and the
// sorted values are then shifted out of cell 0 up to the middle rank. A
// non-emitting sample leaves the block idle. The result sits in an output
// register, so the next sample can be taken while it waits. A new window
// size may be written only while the block is idle; it applies from the
// next sample on. The stream restarts only on reset.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = DEFAULT_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    swm_sample_if.sink         samples,
    swm_median_if.source       medians,
    swm_cfg_if.sink            cfg
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW = $clog2(MAX_WINDOW + 1);
    localparam int CW = $clog2(MAX_WINDOW + 2);
    localparam int OW = SAMPLE_WIDTH + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FEED   = 3'd1;
    localparam logic [2:0] S_SETTLE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [CFG_WIDTH-1:0]           wsize_reg;
    logic [FW-1:0]                  fill_reg;
    logic [FW-1:0]                  fill_next;
    logic [AW-1:0]                  wr_ptr_reg;
    logic [AW-1:0]                  rd_addr_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           feed_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] ring_q_reg;
    logic signed [SAMPLE_WIDTH-1:0] lo_reg;
    logic signed [SAMPLE_WIDTH-1:0] hi_reg;
    logic                           out_vld_reg;
    logic signed [OW-1:0]           median_reg;

    logic signed [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];

    logic                           in_acc;
    logic                           out_free;
    logic [CW-1:0]                  k_eff;
    logic [CW-1:0]                  half_k;
    logic signed [OW-1:0]           median_calc;
    logic signed [SAMPLE_WIDTH-1:0] head_data;
    swm_cell_ctrl_t                 cell_ctrl;

    assign in_acc   = samples.valid && samples.ready;
    assign out_free = !out_vld_reg || medians.ready;

    // effective window length
    always_comb
    begin
        if (wsize_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (32'(wsize_reg) > 32'(MAX_WINDOW))
        begin
            k_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            k_eff = CW'(wsize_reg);
        end
    end

    assign half_k    = k_eff >> 1;
    assign fill_next = (fill_reg == FW'(MAX_WINDOW)) ? fill_reg : fill_reg + FW'(1);

    // odd window: twice the middle; even: sum of the two middle values
    assign median_calc = k_eff[0] ? {hi_reg, 1'b0}
                                  : {lo_reg[SAMPLE_WIDTH-1], lo_reg}
                                    + {hi_reg[SAMPLE_WIDTH-1], hi_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (CW'(fill_next) >= k_eff))
                begin
                    state_next = S_FEED;
                end
            end
            S_FEED:
            begin
                if (cnt_reg == k_eff - CW'(1))
                begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                if (cnt_reg == k_eff + CW'(1))
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (cnt_reg == half_k)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // chain is emptied on every accepted request
    assign cell_ctrl.clear = in_acc;
    assign cell_ctrl.shift = (state_reg == S_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wsize_reg    <= WINDOW_SIZE_RESET;
            fill_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_addr_reg  <= '0;
            cnt_reg      <= '0;
            feed_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            feed_vld_reg <= (state_reg == S_FEED);

            if (cfg.valid && cfg.ready)
            begin
                wsize_reg <= cfg.win_len;
            end

            if (in_acc)
            begin
                fill_reg    <= fill_next;
                rd_addr_reg <= wr_ptr_reg;
                wr_ptr_reg  <= (wr_ptr_reg == AW'(MAX_WINDOW - 1)) ? '0
                                                                    : wr_ptr_reg + AW'(1);
            end
            else if (state_reg == S_FEED)
            begin
                // walk back from the newest sample, wrapping round the ring
                rd_addr_reg <= (rd_addr_reg == '0) ? AW'(MAX_WINDOW - 1)
                                                   : rd_addr_reg - AW'(1);
            end

            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg != S_IDLE)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end

            if (state_reg == S_DONE && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (medians.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ring store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ring_mem[wr_ptr_reg] <= samples.sample;
        end
        ring_q_reg <= ring_mem[rd_addr_reg];
    end

    // middle ranks captured as they pass through cell 0
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SHIFT)
        begin
            if (cnt_reg == half_k - CW'(1))
            begin
                lo_reg <= head_data;
            end
            if (cnt_reg == half_k)
            begin
                hi_reg <= head_data;
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            median_reg <= median_calc;
        end
    end

    swm_chain #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .in_valid  (feed_vld_reg),
        .in_data   (ring_q_reg),
        .head_data (head_data)
    );

    assign samples.ready          = (state_reg == S_IDLE);
    assign cfg.ready              = 1'b1;
    assign medians.valid          = out_vld_reg;
    assign medians.median_doubled = median_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Running median filter bench: samples go in through a random gap generator,
// medians come out through a random stall generator, and every accepted
// median is checked against a local predictor of the ring and the sort.
module tb;
    import swm_pkg::*;

    localparam int MAX_WIN     = DEFAULT_MAX_WINDOW;
    localparam int SW          = DEFAULT_SAMPLE_WIDTH;
    localparam int CYCLE_LIMIT = 3_000_000;
    // worst-case busy time of one emitting request at K = 32, plus margin
    localparam int DRAIN_CYCLES = 120;

    // sample mixes
    localparam int unsigned MIX_FULL    = 0;    // full range
    localparam int unsigned MIX_NARROW  = 1;    // narrow, many ties
    localparam int unsigned MIX_EXTREME = 2;    // mixed with extremes

    logic clk;
    logic rst_n;

    swm_sample_if #(.SAMPLE_WIDTH(SW)) smp_if ();
    swm_median_if #(.SAMPLE_WIDTH(SW)) med_if ();
    swm_cfg_if                         cfg_if ();

    sliding_window_median #(
        .MAX_WINDOW   (MAX_WIN),
        .SAMPLE_WIDTH (SW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp_if),
        .medians (med_if),
        .cfg     (cfg_if)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the ring, the fill level and the
    // window register, plus the queue of medians still to come out.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] ring_mem [MAX_WIN];
    int unsigned          held_count;
    int unsigned          next_slot;
    logic [CFG_WIDTH-1:0] win_reg;
    logic signed [SW:0]   median_q [$];

    int unsigned fail_count;
    int unsigned cycle_count;

    // idling controls, changed per phase
    bit          tx_gaps_on;
    bit          rx_stall_on;
    int unsigned stall_left;
    int unsigned sample_mix;

    logic signed [SW:0] head_median;

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Gap lengths: drawn mostly from the shortest of three ranges, now and then from the longest.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (sample_mix)
            MIX_NARROW: return SW'($signed($urandom_range(0, 8)) - 4);
            MIX_EXTREME:
            begin
                if (r < 15)
                    return {1'b1, {(SW-1){1'b0}}};
                if (r < 30)
                    return {1'b0, {(SW-1){1'b1}}};
                if (r < 40)
                    return '1;
                if (r < 50)
                    return '0;
                return SW'($urandom());
            end
            default: return SW'($urandom());
        endcase
    endfunction

    // Effective window: zero reads as one, anything past the ring depth is clipped.
    function automatic int unsigned eff_window(logic [CFG_WIDTH-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WIN)
            return MAX_WIN;
        return w;
    endfunction

    // Store the sample, and once the window is full queue twice its median.
    function automatic void predict_median(logic signed [SW-1:0] s);
        int unsigned          k;
        int unsigned          i;
        int unsigned          j;
        int unsigned          slot;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] sorted_vals [MAX_WIN];
        logic signed [SW:0]   m;
        k = eff_window(win_reg);
        ring_mem[next_slot] = s;
        next_slot = (next_slot + 1) % MAX_WIN;
        if (held_count < MAX_WIN)
            held_count++;
        if (held_count < k)
            return;
        // insertion sort of the newest k samples
        for (i = 0; i < k; i++)
        begin
            slot = (next_slot + MAX_WIN - 1 - i) % MAX_WIN;
            v = ring_mem[slot];
            j = i;
            while (j > 0 && sorted_vals[j-1] > v)
            begin
                sorted_vals[j] = sorted_vals[j-1];
                j--;
            end
            sorted_vals[j] = v;
        end
        if (k % 2 == 1)
            m = {sorted_vals[k/2], 1'b0};
        else
            m = {sorted_vals[k/2-1][SW-1], sorted_vals[k/2-1]}
              + {sorted_vals[k/2][SW-1], sorted_vals[k/2]};
        median_q.insert(median_q.size(), m);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure, and the check of every median
    // against the oldest one predicted.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            med_if.ready <= 1'b0;
        end
        else if (rx_stall_on && $urandom_range(0, 3) == 0)
        begin
            stall_left   <= gap_len() - 1;
            med_if.ready <= 1'b0;
        end
        else
        begin
            med_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && med_if.valid && med_if.ready)
        begin
            if (median_q.size() == 0)
            begin
                $error("median_doubled: no median expected, got %0d", med_if.median_doubled);
                fail_count++;
            end
            else
            begin
                head_median = median_q.pop_front();
                if (med_if.median_doubled !== head_median)
                begin
                    $error("median_doubled: expected %0d, got %0d",
                           head_median, med_if.median_doubled);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // One sample request, with an optional gap first. Valid is left high
    // after acceptance; the next negedge either carries the next request
    // or lowers it.
    task automatic send_sample(input logic signed [SW-1:0] s);
        int unsigned n;
        n = (tx_gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (n > 0)
        begin
            @(negedge clk);
            smp_if.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do
            @(posedge clk);
        while (!smp_if.ready);
        predict_median(s);
    endtask

    // Drop valid, let every predicted median out, then give the block time
    // to finish a sample that yields nothing.
    task automatic wait_idle();
        @(negedge clk);
        smp_if.valid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [CFG_WIDTH-1:0] w);
        wait_idle();
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.win_len <= w;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        win_reg = w;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window of three: nothing until three samples are held, then
    // both ends of the sample range.
    task automatic test_fill_and_extremes();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        repeat (3) send_sample({1'b1, {(SW-1){1'b0}}});
        repeat (3) send_sample({1'b0, {(SW-1){1'b1}}});
    endtask

    // Even window averages the middle pair, odd takes the middle value.
    task automatic test_even_and_odd_windows();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        set_window(6'd2);
        send_sample({1'b0, {(SW-1){1'b1}}});
        send_sample({1'b1, {(SW-1){1'b0}}});
        set_window(6'd4);
        send_sample(-16'sd3);
        send_sample(16'sd8);
        set_window(6'd1);
        send_sample(16'sd1234);
        send_sample(-16'sd1);
    endtask

    // Zero window acts as one; an oversized window clips to the ring depth
    // and stays silent until that many samples have arrived since reset.
    task automatic test_window_limits();
        set_window(6'd0);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        set_window(6'd63);
        repeat (6) send_sample(pick_sample());
    endtask

    // Phases of random samples, each under its own window size and idling mix.
    // Mostly small windows, which keep the sort short; a few at the limits.
    task automatic test_random_stream();
        int unsigned          p;
        int unsigned          r;
        logic [CFG_WIDTH-1:0] w;
        for (p = 0; p < 20; p++)
        begin
            r = $urandom_range(0, 99);
            case (p)
                5, 18:   w = 6'd32;
                8:       w = CFG_WIDTH'($urandom_range(33, 62));
                12:      w = 6'd63;
                15:      w = 6'd0;
                default: w = (r < 75) ? CFG_WIDTH'($urandom_range(1, 8))
                                      : CFG_WIDTH'($urandom_range(9, 31));
            endcase
            set_window(w);
            // every fourth phase runs flat out on both sides
            tx_gaps_on  = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
            rx_stall_on = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
            sample_mix  = $urandom_range(MIX_FULL, MIX_EXTREME);
            repeat (82) send_sample(pick_sample());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        smp_if.valid   = 1'b0;
        smp_if.sample  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.win_len = '0;
        med_if.ready   = 1'b0;
        stall_left     = 0;
        tx_gaps_on     = 1'b0;
        rx_stall_on    = 1'b0;
        sample_mix     = MIX_EXTREME;
        fail_count     = 0;
        cycle_count    = 0;
        held_count     = 0;
        next_slot      = 0;
        win_reg        = WINDOW_SIZE_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fill_and_extremes();
        test_even_and_odd_windows();
        test_window_limits();
        test_random_stream();

        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hdl/swm_pkg.sv
hdl/swm_ifs.sv
hdl/swm_cell.sv
hdl/swm_chain.sv
hdl/sliding_window_median.sv
tb/tb.sv
